/* hw/rtl/crc16_pkg.sv */
// Shared types, constants and bit-level CRC functions for the CRC-16 engine.
package crc16_pkg;

  localparam int CRC_W  = 16;
  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CRC_W-1:0] POLY_RST = 16'h1021;
  localparam logic [CRC_W-1:0] INIT_RST = 16'h0000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLYNOMIAL    = 8'd0,
    CFG_INITIAL_VALUE = 8'd1,
    CFG_LSB_FIRST     = 8'd2,
    CFG_REFLECT_CRC   = 8'd3
  } cfg_idx_t;

  typedef logic [CRC_W-1:0]  crc_t;
  typedef logic [BYTE_W-1:0] byte_t;

  // Shift one byte into the low end of the register, one bit per step,
  // folding the polynomial in whenever bit 15 falls out.
  function automatic crc_t crc16_absorb(input crc_t crc, input byte_t din,
                                        input logic lsb_first, input crc_t poly);
    crc_t r;
    logic carry;
    logic bit_in;
    r = crc;
    for (int i = 0; i < BYTE_W; i++) begin
      carry  = r[CRC_W-1];
      bit_in = lsb_first ? din[3'(i)] : din[3'(BYTE_W - 1 - i)];
      r      = {r[CRC_W-2:0], bit_in};
      if (carry) begin
        r = r ^ poly;
      end
    end
    return r;
  endfunction

  function automatic crc_t crc16_reverse(input crc_t v);
    crc_t r;
    for (int i = 0; i < CRC_W; i++) begin
      r[4'(i)] = v[4'(CRC_W - 1 - i)];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/crc16_if.sv */
// Handshake channel interfaces for the CRC-16 engine: input bytes, results, config writes.
interface crc16_in_if;
  logic                         valid;
  logic                         ready;
  logic [crc16_pkg::BYTE_W-1:0] data_byte;
  logic                         last;
  modport source (output valid, data_byte, last, input ready);
  modport sink   (input valid, data_byte, last, output ready);
endinterface

interface crc16_out_if;
  logic                        valid;
  logic                        ready;
  logic [crc16_pkg::CRC_W-1:0] crc_value;
  modport source (output valid, crc_value, input ready);
  modport sink   (input valid, crc_value, output ready);
endinterface

interface crc16_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [crc16_pkg::CFG_IDX_W-1:0]  index;
  logic [crc16_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/crc16_bitwise_augmented.sv */
// CRC-16 engine top level: augmented bitwise CRC over a byte stream, one byte per cycle.
//
// The engine takes one message byte per cycle on in_if and, for the byte marked last,
// returns the finished CRC-16 on out_if. Each byte is shifted into the low end of the
// register (MSB or LSB first per lsb_first) with the polynomial folded in on every carry
// out of bit 15; after the last byte two zero bytes are flushed, the register is
// optionally bit-reversed, and the result is presented. The first byte of a message
// loads initial_value (bit-reversed when reflect_crc is set). Throughput is one item
// per cycle whenever out_if is not stalled. An accepted last byte travels through the
// input register, the byte absorb stage, the first zero-byte flush stage, and the
// result register, which takes the second flush plus output reversal. The byte absorb
// into the running register is the only feedback path, eight shift steps deep. A stall
// on out_if holds the whole pipe and drops in_if.ready.
// Write configuration only while no message is open and no result is in flight; cfg_if
// is always ready and writes to unknown indexes are ignored.
module crc16_bitwise_augmented (
  input  logic         clk,
  input  logic         rst_n,
  crc16_in_if.sink     in_if,
  crc16_out_if.source  out_if,
  crc16_cfg_if.sink    cfg_if
);
  import crc16_pkg::*;

  // Configuration registers
  crc_t poly_r;
  crc_t init_r;
  logic lsb_first_r;
  logic reflect_r;

  // Pipe control: everything advances together unless the result is stalled
  logic adv;

  // Input register
  logic  s1_vld_r;
  byte_t s1_byte_r;
  logic  s1_last_r;

  // Running register and message flag
  crc_t crc_r;
  crc_t crc_nxt;
  logic in_msg_r;
  crc_t crc_start;

  // Flush stages (carry only last bytes)
  logic s2_vld_r;
  crc_t s2_crc_r;
  logic s3_vld_r;
  crc_t s3_crc_r;
  crc_t s3_flush;

  // Result register
  logic out_vld_r;
  crc_t out_crc_r;

  assign adv          = !out_vld_r || out_if.ready;
  assign in_if.ready  = adv;
  assign cfg_if.ready = 1'b1;

  // Config decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r      <= POLY_RST;
      init_r      <= INIT_RST;
      lsb_first_r <= 1'b0;
      reflect_r   <= 1'b0;
    end else if (cfg_if.valid) begin
      unique case (cfg_idx_t'(cfg_if.index))
        CFG_POLYNOMIAL:    poly_r      <= cfg_if.data;
        CFG_INITIAL_VALUE: init_r      <= cfg_if.data;
        CFG_LSB_FIRST:     lsb_first_r <= cfg_if.data[0];
        CFG_REFLECT_CRC:   reflect_r   <= cfg_if.data[0];
        default: ;
      endcase
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_byte_r <= in_if.data_byte;
      s1_last_r <= in_if.last;
    end
  end

  // Absorb the byte; a fresh message starts from the (optionally reversed) initial value
  always_comb begin
    crc_start = in_msg_r ? crc_r : (reflect_r ? crc16_reverse(init_r) : init_r);
    crc_nxt   = crc16_absorb(crc_start, s1_byte_r, lsb_first_r, poly_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= '0;
      in_msg_r <= 1'b0;
    end else if (adv && s1_vld_r) begin
      crc_r    <= crc_nxt;
      in_msg_r <= !s1_last_r;
    end
  end

  // Valid flags of the flush stages and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r  <= s1_vld_r && s1_last_r;
      s3_vld_r  <= s2_vld_r;
      out_vld_r <= s3_vld_r;
    end
  end

  // Flush stage data: absorb capture, first and second zero-byte flush, output reversal
  assign s3_flush = crc16_absorb(s3_crc_r, '0, lsb_first_r, poly_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_crc_r  <= crc_nxt;
      s3_crc_r  <= crc16_absorb(s2_crc_r, '0, lsb_first_r, poly_r);
      out_crc_r <= reflect_r ? crc16_reverse(s3_flush) : s3_flush;
    end
  end

  assign out_if.valid     = out_vld_r;
  assign out_if.crc_value = out_crc_r;

  // A finished flush always lands in the result register
  a_flush_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s3_vld_r) |=> out_vld_r)
    else $error("flushed CRC did not reach the result register");

  // The message closes only when a last byte is absorbed
  a_msg_close: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_msg_r) |-> $past(s1_vld_r && s1_last_r && adv))
    else $error("message closed without a last byte");

  // A stall freezes the running register
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(crc_r) && $stable(in_msg_r)))
    else $error("running CRC changed during a stall");

  // Only last bytes enter the flush pipe
  a_flush_src: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_vld_r && !s1_last_r) |=> !s2_vld_r)
    else $error("non-last byte entered the flush stages");

endmodule

/* test/crc16_bitwise_augmented_tb.sv */
// Testbench for the augmented bitwise CRC-16 engine: predicts each message CRC and checks it.
`timescale 1ns / 100ps

module crc16_bitwise_augmented_tb;
  import crc16_pkg::*;

  // Indexes outside the register map; writes there must leave every setting alone.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 8'hFF;

  // Extra drain margin after the last result, before touching config or ending.
  localparam int DRAIN_CYCLES  = 8;
  // Longest legal quiet stretch is the long receiver hold-off below, so this is ample.
  localparam int QUIET_LIMIT   = 3000;
  localparam int HOLD_OFF_LEN  = 300;
  localparam int REPORT_LIMIT  = 10;

  logic clk = 1'b0;
  logic rst_n;

  crc16_in_if  in_ch ();
  crc16_out_if out_ch ();
  crc16_cfg_if cfg_ch ();

  crc16_bitwise_augmented u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: shadow copy of the config registers and the running CRC.
  // Values after reset match the block's documented register defaults.
  // ---------------------------------------------------------------------------
  crc_t poly_m     = POLY_RST;
  crc_t init_m     = INIT_RST;
  logic lsb_m      = 1'b0;
  logic refl_m     = 1'b0;
  crc_t crc_run_m  = '0;
  logic msg_open_m = 1'b0;

  crc_t crc_expect_q[$];   // finished CRCs waiting for the block to emit them
  int   mismatch_cnt = 0;
  int   quiet_cycles = 0;

  // Stimulus side controls, set from the test tasks.
  logic msg_open_tx = 1'b0; // sender's own view: a message has bytes but no last yet
  bit   src_jitter  = 1'b0;
  bit   sink_jitter = 1'b0;
  int   sink_hold   = 0;

  function automatic crc_t mirror16(crc_t v);
    crc_t m;
    m = {<<{v}};
    return m;
  endfunction

  // Push eight bits into the low end of the register; fold the polynomial in on carry.
  function automatic crc_t shift_in_byte(crc_t acc, byte_t b);
    crc_t  r;
    byte_t ordered;
    logic  carry;
    r = acc;
    if (lsb_m) begin
      ordered = {<<{b}};
    end else begin
      ordered = b;
    end
    for (int k = 0; k < BYTE_W; k++) begin
      carry   = r[CRC_W-1];
      r       = {r[CRC_W-2:0], ordered[BYTE_W-1]};
      ordered = ordered << 1;
      if (carry) begin
        r = r ^ poly_m;
      end
    end
    return r;
  endfunction

  function automatic void log_mismatch(string what, crc_t exp_v, crc_t got_v);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_LIMIT) begin
      $display("[%0t] %s: expected %h, got %h", $time, what, exp_v, got_v);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input side monitor: track config writes and predict on every accepted item.
  // Config and data never overlap, so handling both here keeps ordering fixed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    crc_t r;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_POLYNOMIAL:    poly_m = cfg_ch.data;
          CFG_INITIAL_VALUE: init_m = cfg_ch.data;
          CFG_LSB_FIRST:     lsb_m  = cfg_ch.data[0];
          CFG_REFLECT_CRC:   refl_m = cfg_ch.data[0];
          default: ;  // unmapped index: drop the write
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        // First byte of a message reloads the start value, mirrored if reflecting.
        if (msg_open_m) begin
          r = crc_run_m;
        end else begin
          r = refl_m ? mirror16(init_m) : init_m;
        end
        msg_open_m = 1'b1;
        r = shift_in_byte(r, in_ch.data_byte);
        if (in_ch.last) begin
          // Augment with two zero bytes, then apply the output mirror.
          r = shift_in_byte(r, '0);
          r = shift_in_byte(r, '0);
          if (refl_m) begin
            r = mirror16(r);
          end
          msg_open_m = 1'b0;
          crc_expect_q.push_back(r);
        end
        crc_run_m = r;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted CRC against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    crc_t exp_v;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (crc_expect_q.size() == 0) begin
        log_mismatch("unexpected crc_value", '0, out_ch.crc_value);
      end else begin
        exp_v = crc_expect_q.pop_front();
        if (out_ch.crc_value !== exp_v) begin
          log_mismatch("crc_value", exp_v, out_ch.crc_value);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if no channel moves an item for too long.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("crc16_bitwise_augmented test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready bursts, plus a long hold-off when a test asks for one.
  // The hold-off is counted here so the sender can keep offering items meanwhile.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int burst;
    out_ch.ready = 1'b1;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
        out_ch.ready <= 1'b1;
      end else if (sink_jitter && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 17);
        out_ch.ready <= 1'b0;
        repeat (burst) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: offer one byte, optionally after a random gap, and hold until taken.
  // Valid stays high on return so back-to-back items go out at full rate.
  // ---------------------------------------------------------------------------
  task automatic send_byte(byte_t b, logic is_last);
    int gap;
    if (src_jitter && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last      <= is_last;
    do @(posedge clk); while (!in_ch.ready);
    msg_open_tx = !is_last;
  endtask

  task automatic send_random_message(int len);
    for (int i = 0; i < len; i++) begin
      send_byte(byte_t'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // Close any open message, drop valid, and wait for the pipe to empty.
  task automatic settle();
    if (msg_open_tx) begin
      send_byte(byte_t'($urandom_range(0, 255)), 1'b1);
    end
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (crc_expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leave valid high on return; the caller lowers it once after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Reprogram every register while idle; optionally poke the unmapped indexes too.
  task automatic apply_setting(crc_t poly, crc_t init, logic lsb, logic refl,
                               bit with_spare = 1'b0);
    settle();
    write_reg(CFG_POLYNOMIAL, poly);
    write_reg(CFG_INITIAL_VALUE, init);
    write_reg(CFG_LSB_FIRST, CFG_DATA_W'(lsb));
    write_reg(CFG_REFLECT_CRC, CFG_DATA_W'(refl));
    if (with_spare) begin
      write_reg(CFG_IDX_SPARE, 16'hDEAD);
      write_reg(CFG_IDX_TOP, 16'hBEEF);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Random setting, biased toward the corners of each register.
  task automatic apply_random_setting();
    crc_t poly;
    crc_t init;
    case ($urandom_range(0, 5))
      0:       poly = 16'h0001;
      1:       poly = 16'hFFFF;
      2:       poly = 16'h8000;
      default: poly = crc_t'($urandom_range(1, 65535));
    endcase
    case ($urandom_range(0, 3))
      0:       init = 16'h0000;
      1:       init = 16'hFFFF;
      default: init = crc_t'($urandom_range(0, 65535));
    endcase
    apply_setting(poly, init, logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)),
                  $urandom_range(0, 7) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults: single-byte messages at both byte extremes, the classic check
  // string, and lone top and bottom bits.
  task automatic test_reset_defaults();
    byte_t check_str[9];
    check_str = '{"1", "2", "3", "4", "5", "6", "7", "8", "9"};
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    foreach (check_str[i]) begin
      send_byte(check_str[i], i == 8);
    end
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    settle();
  endtask

  // Register corners: smallest and largest polynomial, both bit orders, both
  // reflect modes, a zero polynomial (shift only), and writes to unmapped indexes.
  task automatic test_config_corners();
    apply_setting(16'h0001, 16'h0000, 1'b0, 1'b0);
    send_byte(8'hA5, 1'b1);
    apply_setting(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    apply_setting(16'h0000, 16'h1234, 1'b1, 1'b0);
    send_byte(8'h5A, 1'b1);
    apply_setting(16'h8005, 16'hFFFF, 1'b0, 1'b1, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1);
    settle();
  endtask

  // Bulk random traffic with idling on both sides and settings changed between
  // groups of messages. Mostly short messages, now and then a long one.
  task automatic test_random_traffic(int n_items);
    int sent;
    int len;
    src_jitter  = 1'b1;
    sink_jitter = 1'b1;
    sent = 0;
    while (sent < n_items) begin
      apply_random_setting();
      repeat ($urandom_range(4, 14)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        send_random_message(len);
        sent += len;
      end
    end
    settle();
  endtask

  // Hold the receiver off for a long stretch while the sender keeps pushing short
  // messages, so the pipe fills and the input stalls.
  task automatic test_backpressure();
    int sent;
    int len;
    src_jitter  = 1'b0;
    sink_jitter = 1'b0;
    apply_random_setting();
    sink_hold = HOLD_OFF_LEN;
    sent = 0;
    while (sent < 60) begin
      len = $urandom_range(1, 3);
      send_random_message(len);
      sent += len;
    end
    settle();
  endtask

  // Final stretch at full rate: no idling on either side.
  task automatic test_full_rate(int n_items);
    int sent;
    int len;
    src_jitter  = 1'b0;
    sink_jitter = 1'b0;
    apply_random_setting();
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 10);
      send_random_message(len);
      sent += len;
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset once, then run the tests in turn and report.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.last       = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_config_corners();
    test_random_traffic(1500);
    test_backpressure();
    test_full_rate(250);

    if (mismatch_cnt == 0 && crc_expect_q.size() == 0) begin
      $display("crc16_bitwise_augmented test passed");
    end else begin
      $display("crc16_bitwise_augmented test failed");
    end
    $finish;
  end

endmodule
